@@ hdl/vpw_pkg.sv @@
// Package for the vertex projection block: widths, register codes, shared types
// and the fixed-point helpers used by the front, back and divider modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vpw_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int DATA_WIDTH  = 32;
	localparam int COORD_W     = 32;
	localparam int COEF_W      = 32;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int STORE_DEPTH = 32;
	localparam int IDX_W       = $clog2(STORE_DEPTH);

	localparam int N_ROW  = 4;
	localparam int N_MUL1 = N_ROW * 3;
	localparam int N_MUL2 = N_ROW * 4;
	localparam int N_DIV  = 3;
	localparam int PROJ_BASE = STORE_DEPTH / 2;

	localparam int VAL_W  = (DATA_WIDTH > COORD_W) ? DATA_WIDTH : COORD_W;
	localparam int PROD_W = COEF_W + VAL_W;
	localparam int SUM_W  = 64;
	localparam logic [PROD_W-1:0] TERM_LIMIT = PROD_W'(1) << 60;

	localparam int DVD_W = DATA_WIDTH + FRAC_BITS;
	localparam int N_W   = 32;
	localparam int NP_W  = N_W + 1;
	localparam int WP_W  = CFG_W + 1 + NP_W;
	localparam logic [DVD_W-1:0] QLIM_POS = DVD_W'(32'h7FFF_FFFF);
	localparam logic [DVD_W-1:0] QLIM_NEG = DVD_W'(32'h8000_0000);
	localparam logic [NP_W-1:0]  ONE_Q    = NP_W'(1) << FRAC_BITS;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int PIPE_DEPTH = 5 + DVD_W + 3;
	localparam int CNT_W      = $clog2(PIPE_DEPTH + FIFO_DEPTH + 1);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_POINT = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_VP_LEFT   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_VP_BOTTOM = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_VP_WIDTH  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_VP_HEIGHT = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_W_EPS     = CFG_IDX_W'(4);

	typedef logic [STORE_DEPTH-1:0][COEF_W-1:0] store_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic signed [COORD_W-1:0] pz;
	} point_t;

	typedef struct packed {
		logic [CFG_W-1:0] vp_left;
		logic [CFG_W-1:0] vp_bottom;
		logic [CFG_W-1:0] vp_width;
		logic [CFG_W-1:0] vp_height;
		logic [CFG_W-1:0] w_epsilon;
	} view_cfg_t;

	typedef struct packed {
		logic             valid;
		logic             ok;
		logic [N_DIV-1:0] neg;
	} div_tag_t;

	function automatic logic [COEF_W-1:0] mag_coef(input logic [COEF_W-1:0] a);
		return a[COEF_W-1] ? (~a + COEF_W'(1)) : a;
	endfunction

	function automatic logic [VAL_W-1:0] mag_val(input logic [VAL_W-1:0] v);
		return v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
	endfunction

	function automatic logic [DATA_WIDTH-1:0] mag_dw(input logic [DATA_WIDTH-1:0] v);
		return v[DATA_WIDTH-1] ? (~v + DATA_WIDTH'(1)) : v;
	endfunction

	// Truncate toward zero, clamp the magnitude, then restore the sign.
	function automatic logic signed [SUM_W-1:0] term(input logic [PROD_W-1:0] p,
		input logic neg);
		logic [PROD_W-1:0] sh;
		logic [SUM_W-1:0]  t;
		sh = p >> FRAC_BITS;
		if (sh > TERM_LIMIT)
			sh = TERM_LIMIT;
		t = sh[SUM_W-1:0];
		return neg ? $signed(~t + SUM_W'(1)) : $signed(t);
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] sat_dw(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = $signed({{(SUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}});
		lo = ~hi;
		if (v > hi)
			return hi[DATA_WIDTH-1:0];
		else if (v < lo)
			return lo[DATA_WIDTH-1:0];
		else
			return v[DATA_WIDTH-1:0];
	endfunction

	function automatic logic signed [N_W-1:0] sat_n(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = $signed({{(SUM_W-N_W+1){1'b0}}, {(N_W-1){1'b1}}});
		lo = ~hi;
		if (v > hi)
			return hi[N_W-1:0];
		else if (v < lo)
			return lo[N_W-1:0];
		else
			return v[N_W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ hdl/vpw_front.sv @@
// Front end: accepts input beats, writes coefficients into the matrix store and
// queues point items for the back end. Depends on vpw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vpw_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            op,
	input  logic [vpw_pkg::IDX_W-1:0]       coef_index,
	input  logic signed [vpw_pkg::COEF_W-1:0] coef_value,
	input  logic signed [vpw_pkg::COORD_W-1:0] px,
	input  logic signed [vpw_pkg::COORD_W-1:0] py,
	input  logic signed [vpw_pkg::COORD_W-1:0] pz,
	input  logic                            pop,
	input  logic                            done,
	output vpw_pkg::point_t                 head,
	output logic                            fifo_empty,
	output vpw_pkg::store_t                 store
);
	import vpw_pkg::*;

	point_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     count_q;
	logic [CNT_W-1:0]     inflight_q;
	store_t               store_q;
	logic                 full;
	logic                 accept;
	logic                 push;
	logic                 do_pop;

	assign full       = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign fifo_empty = (count_q == '0);
	// Hold a coefficient write until every queued or running point has left.
	assign in_stall   = full || ((op == OP_WRITE) && (inflight_q != '0));
	assign accept     = in_valid && !in_stall;
	assign push       = accept && (op == OP_POINT);
	assign do_pop     = pop && !fifo_empty;
	assign head       = mem_q[rd_ptr_q];
	assign store      = store_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			count_q    <= '0;
			inflight_q <= '0;
			store_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			unique case ({push, do_pop})
				2'b10:   count_q <= count_q + (FIFO_AW+1)'(1);
				2'b01:   count_q <= count_q - (FIFO_AW+1)'(1);
				default: count_q <= count_q;
			endcase
			unique case ({push, done})
				2'b10:   inflight_q <= inflight_q + CNT_W'(1);
				2'b01:   inflight_q <= inflight_q - CNT_W'(1);
				default: inflight_q <= inflight_q;
			endcase
			if (accept && (op == OP_WRITE))
				store_q[coef_index] <= coef_value;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= '{px: px, py: py, pz: pz};
	end

endmodule
`default_nettype wire

@@ hdl/vpw_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, three lanes sharing
// one divisor. Carries a tag alongside the data. Depends on vpw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vpw_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  vpw_pkg::div_tag_t                 tag_in,
	input  logic [vpw_pkg::DATA_WIDTH-1:0]    num_in [vpw_pkg::N_DIV],
	input  logic [vpw_pkg::DATA_WIDTH-1:0]    den_in,
	output vpw_pkg::div_tag_t                 tag_out,
	output logic [vpw_pkg::DVD_W-1:0]         quo_out [vpw_pkg::N_DIV]
);
	import vpw_pkg::*;

	logic [DATA_WIDTH-1:0] rem_q   [DVD_W][N_DIV];
	logic [DVD_W-1:0]      dvd_q   [DVD_W][N_DIV];
	logic [DATA_WIDTH-1:0] den_q   [DVD_W];
	div_tag_t              tag_q   [DVD_W];
	logic [DATA_WIDTH-1:0] rem_nxt [DVD_W][N_DIV];
	logic [DVD_W-1:0]      dvd_nxt [DVD_W][N_DIV];
	logic [DATA_WIDTH-1:0] den_nxt [DVD_W];
	div_tag_t              tag_nxt [DVD_W];

	always_comb begin
		logic [DATA_WIDTH-1:0] r_in;
		logic [DVD_W-1:0]      d_in;
		logic [DATA_WIDTH-1:0] dn;
		logic [DATA_WIDTH:0]   trial;
		logic [DATA_WIDTH:0]   diff;
		logic                  ge;
		for (int k = 0; k < DVD_W; k++) begin
			dn = (k == 0) ? den_in : den_q[(k == 0) ? 0 : k-1];
			for (int l = 0; l < N_DIV; l++) begin
				if (k == 0) begin
					r_in = '0;
					d_in = {num_in[l], {FRAC_BITS{1'b0}}};
				end else begin
					r_in = rem_q[k-1][l];
					d_in = dvd_q[k-1][l];
				end
				trial = {r_in, d_in[DVD_W-1]};
				diff  = trial - {1'b0, dn};
				ge    = (trial >= {1'b0, dn});
				rem_nxt[k][l] = ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
				dvd_nxt[k][l] = {d_in[DVD_W-2:0], ge};
			end
			den_nxt[k] = dn;
			tag_nxt[k] = (k == 0) ? tag_in : tag_q[(k == 0) ? 0 : k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DVD_W; k++)
				tag_q[k] <= '0;
		end else if (en) begin
			tag_q <= tag_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= rem_nxt;
			dvd_q <= dvd_nxt;
			den_q <= den_nxt;
		end
	end

	assign tag_out = tag_q[DVD_W-1];
	always_comb begin
		for (int l = 0; l < N_DIV; l++)
			quo_out[l] = dvd_q[DVD_W-1][l];
	end

endmodule
`default_nettype wire

@@ hdl/vpw_back.sv @@
// Back end: modelview and projection products, small-w check, perspective
// divide and viewport mapping, ending in the output register. Depends on
// vpw_pkg and vpw_div.
`timescale 1ns / 1ps
`default_nettype none
module vpw_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  vpw_pkg::point_t                   head,
	input  logic                              fifo_empty,
	output logic                              pop,
	input  vpw_pkg::store_t                   store,
	input  vpw_pkg::view_cfg_t                cfg,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [vpw_pkg::COORD_W-1:0] win_x,
	output logic signed [vpw_pkg::COORD_W-1:0] win_y,
	output logic signed [vpw_pkg::COORD_W-1:0] win_z,
	output logic                              ok
);
	import vpw_pkg::*;

	logic en;

	logic                          v_s1, v_s2, v_s3, v_s4;
	logic [PROD_W-1:0]             prod1_s1 [N_MUL1];
	logic [N_MUL1-1:0]             neg1_s1;
	logic signed [DATA_WIDTH-1:0]  eye_s2 [N_ROW];
	logic [PROD_W-1:0]             prod2_s3 [N_MUL2];
	logic [N_MUL2-1:0]             neg2_s3;
	logic signed [DATA_WIDTH-1:0]  clip_s4 [N_ROW];
	div_tag_t                      tag_s5;
	logic [DATA_WIDTH-1:0]         num_s5 [N_DIV];
	logic [DATA_WIDTH-1:0]         den_s5;
	div_tag_t                      tag_div;
	logic [DVD_W-1:0]              quo_div [N_DIV];
	logic                          v_s6, v_s7, v_s8;
	logic                          ok_s6, ok_s7;
	logic signed [NP_W-1:0]        np_s6 [N_DIV];
	logic signed [WP_W-1:0]        wx_s7, wy_s7;
	logic signed [NP_W-1:0]        z_s7;
	logic signed [COORD_W-1:0]     wx_s8, wy_s8, wz_s8;
	logic                          ok_s8;

	logic [PROD_W-1:0]             prod1_c [N_MUL1];
	logic [N_MUL1-1:0]             neg1_c;
	logic signed [DATA_WIDTH-1:0]  eye_c [N_ROW];
	logic [PROD_W-1:0]             prod2_c [N_MUL2];
	logic [N_MUL2-1:0]             neg2_c;
	logic signed [DATA_WIDTH-1:0]  clip_c [N_ROW];
	div_tag_t                      tag_c;
	logic [DATA_WIDTH-1:0]         num_c [N_DIV];
	logic [DATA_WIDTH-1:0]         den_c;
	logic signed [NP_W-1:0]        np_c [N_DIV];
	logic signed [COORD_W-1:0]     wx_c, wy_c, wz_c;

	// The whole back end advances together unless a finished beat waits.
	assign en  = !(v_s8 && out_stall);
	assign pop = en && !fifo_empty;

	// Modelview products: lane k uses coefficient k and column k/4 of the point.
	always_comb begin
		logic [VAL_W-1:0] vin [3];
		vin[0] = VAL_W'(head.px);
		vin[1] = VAL_W'(head.py);
		vin[2] = VAL_W'(head.pz);
		for (int k = 0; k < N_MUL1; k++) begin
			prod1_c[k] = PROD_W'(mag_coef(store[k])) * PROD_W'(mag_val(vin[k/N_ROW]));
			neg1_c[k]  = store[k][COEF_W-1] ^ vin[k/N_ROW][VAL_W-1];
		end
	end

	always_comb begin
		logic signed [SUM_W-1:0] acc;
		for (int r = 0; r < N_ROW; r++) begin
			acc = term(prod1_s1[r], neg1_s1[r]) + term(prod1_s1[N_ROW+r], neg1_s1[N_ROW+r])
				+ term(prod1_s1[2*N_ROW+r], neg1_s1[2*N_ROW+r])
				+ SUM_W'($signed(store[3*N_ROW+r]));
			eye_c[r] = sat_dw(acc);
		end
	end

	always_comb begin
		logic [VAL_W-1:0] ev;
		for (int k = 0; k < N_MUL2; k++) begin
			ev = VAL_W'(eye_s2[k/N_ROW]);
			prod2_c[k] = PROD_W'(mag_coef(store[PROJ_BASE+k])) * PROD_W'(mag_val(ev));
			neg2_c[k]  = store[PROJ_BASE+k][COEF_W-1] ^ ev[VAL_W-1];
		end
	end

	always_comb begin
		logic signed [SUM_W-1:0] acc;
		for (int r = 0; r < N_ROW; r++) begin
			acc = '0;
			for (int c = 0; c < N_ROW; c++)
				acc = acc + term(prod2_s3[c*N_ROW+r], neg2_s3[c*N_ROW+r]);
			clip_c[r] = sat_dw(acc);
		end
	end

	// Small-w check and divider operands.
	always_comb begin
		den_c = mag_dw(clip_s4[N_ROW-1]);
		for (int l = 0; l < N_DIV; l++) begin
			num_c[l]     = mag_dw(clip_s4[l]);
			tag_c.neg[l] = clip_s4[l][DATA_WIDTH-1] ^ clip_s4[N_ROW-1][DATA_WIDTH-1];
		end
		tag_c.valid = v_s4;
		tag_c.ok    = (clip_s4[N_ROW-1] != '0) && (den_c >= DATA_WIDTH'(cfg.w_epsilon));
	end

	vpw_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.tag_in  (tag_s5),
		.num_in  (num_s5),
		.den_in  (den_s5),
		.tag_out (tag_div),
		.quo_out (quo_div)
	);

	// Clamp the quotient, apply the sign and add one.
	always_comb begin
		logic [DVD_W-1:0] qc;
		logic [DVD_W-1:0] qs;
		logic [N_W-1:0]   n;
		for (int l = 0; l < N_DIV; l++) begin
			qc = quo_div[l];
			if (tag_div.neg[l] && (qc > QLIM_NEG))
				qc = QLIM_NEG;
			else if (!tag_div.neg[l] && (qc > QLIM_POS))
				qc = QLIM_POS;
			qs = tag_div.neg[l] ? (~qc + DVD_W'(1)) : qc;
			n  = qs[N_W-1:0];
			np_c[l] = NP_W'($signed(n)) + $signed(ONE_Q);
		end
	end

	always_comb begin
		logic signed [SUM_W-1:0] ox, oy;
		ox = $signed(SUM_W'(cfg.vp_left) << FRAC_BITS);
		oy = $signed(SUM_W'(cfg.vp_bottom) << FRAC_BITS);
		if (ok_s7) begin
			wx_c = sat_n(ox + (SUM_W'(wx_s7) >>> 1));
			wy_c = sat_n(oy + (SUM_W'(wy_s7) >>> 1));
			wz_c = sat_n(SUM_W'(z_s7) >>> 1);
		end else begin
			wx_c = '0;
			wy_c = '0;
			wz_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			tag_s5 <= '0;
			v_s6   <= 1'b0;
			v_s7   <= 1'b0;
			v_s8   <= 1'b0;
		end else if (en) begin
			v_s1   <= pop;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			tag_s5 <= tag_c;
			v_s6   <= tag_div.valid;
			v_s7   <= v_s6;
			v_s8   <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod1_s1 <= prod1_c;
			neg1_s1  <= neg1_c;
			eye_s2   <= eye_c;
			prod2_s3 <= prod2_c;
			neg2_s3  <= neg2_c;
			clip_s4  <= clip_c;
			num_s5   <= num_c;
			den_s5   <= den_c;
			np_s6    <= np_c;
			ok_s6    <= tag_div.ok;
			wx_s7    <= $signed({1'b0, cfg.vp_width}) * np_s6[0];
			wy_s7    <= $signed({1'b0, cfg.vp_height}) * np_s6[1];
			z_s7     <= np_s6[2];
			ok_s7    <= ok_s6;
			wx_s8    <= wx_c;
			wy_s8    <= wy_c;
			wz_s8    <= wz_c;
			ok_s8    <= ok_s7;
		end
	end

	assign out_valid = v_s8;
	assign win_x     = wx_s8;
	assign win_y     = wy_s8;
	assign win_z     = wz_s8;
	assign ok        = ok_s8;

endmodule
`default_nettype wire

@@ hdl/vertex_project_to_window_top.sv @@
// Pipeline: a point beat passes 4 matrix stages, one divider setup stage, 48 divider
// stages and 3 viewport stages on its way to out_valid.
// Throughput: one point per cycle while out_stall is low; a coefficient write is held
// until no point is in flight.
// Reset: arst_n clears the matrix store, the queue, all valid flags and the viewport
// registers (w_epsilon to 1).
// Top level: viewport registers and front/back wiring. Depends on vpw_pkg,
// vpw_front, vpw_div and vpw_back.
`timescale 1ns / 1ps
`default_nettype none
module vertex_project_to_window_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic [vpw_pkg::IDX_W-1:0]           coef_index,
	input  logic signed [vpw_pkg::COEF_W-1:0]   coef_value,
	input  logic signed [vpw_pkg::COORD_W-1:0]  px,
	input  logic signed [vpw_pkg::COORD_W-1:0]  py,
	input  logic signed [vpw_pkg::COORD_W-1:0]  pz,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [vpw_pkg::COORD_W-1:0]  win_x,
	output logic signed [vpw_pkg::COORD_W-1:0]  win_y,
	output logic signed [vpw_pkg::COORD_W-1:0]  win_z,
	output logic                                ok,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [vpw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [vpw_pkg::CFG_W-1:0]           cfg_data
);
	import vpw_pkg::*;

	view_cfg_t cfg_q;
	point_t    head;
	store_t    store;
	logic      fifo_empty;
	logic      pop;
	logic      done;

	assign cfg_ready = 1'b1;
	assign done      = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vp_left   <= '0;
			cfg_q.vp_bottom <= '0;
			cfg_q.vp_width  <= '0;
			cfg_q.vp_height <= '0;
			cfg_q.w_epsilon <= CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_VP_LEFT:   cfg_q.vp_left   <= cfg_data;
				CFG_VP_BOTTOM: cfg_q.vp_bottom <= cfg_data;
				CFG_VP_WIDTH:  cfg_q.vp_width  <= cfg_data;
				CFG_VP_HEIGHT: cfg_q.vp_height <= cfg_data;
				CFG_W_EPS:     cfg_q.w_epsilon <= cfg_data;
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	vpw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.px         (px),
		.py         (py),
		.pz         (pz),
		.pop        (pop),
		.done       (done),
		.head       (head),
		.fifo_empty (fifo_empty),
		.store      (store)
	);

	vpw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.fifo_empty (fifo_empty),
		.pop        (pop),
		.store      (store),
		.cfg        (cfg_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.win_x      (win_x),
		.win_y      (win_y),
		.win_z      (win_z),
		.ok         (ok)
	);

endmodule
`default_nettype wire

@@ hdl/vpw_checker.sv @@
// Port-level checks for the projection block, bound to the top level.
// Depends on vpw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vpw_props (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic                                op,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [vpw_pkg::COORD_W-1:0]  win_x,
	input  logic signed [vpw_pkg::COORD_W-1:0]  win_y,
	input  logic signed [vpw_pkg::COORD_W-1:0]  win_z,
	input  logic                                ok
);
	import vpw_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(win_x) && $stable(win_y) && $stable(win_z)
			&& $stable(ok))
		else $error("result beat changed while stalled");

	// A failed projection reports zero coordinates.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> (win_x == '0) && (win_y == '0) && (win_z == '0))
		else $error("failed projection with nonzero coordinates");

	// Coefficient writes wait until all pending results are delivered.
	a_write_drained: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (op == OP_WRITE) |-> !out_valid)
		else $error("coefficient write accepted with a result pending");

endmodule

bind vertex_project_to_window_top vpw_props u_chk (.*);
`default_nettype wire
